// File: hdl/dlps_pkg.sv
// Shared types and constants for the debounced LED pattern sequencer.
package dlps_pkg;

    // Default sizes handed to the top level, and the button count
    localparam int LED_COUNT_DEF      = 8;
    localparam int DEBOUNCE_DEPTH_DEF = 8;
    localparam int BUTTON_COUNT       = 4;

    // Remainder unit sizes: 24-bit dividend, 11-bit remainder
    localparam int DIV_W     = 24;
    localparam int DIVISOR_W = 11;

    // Reciprocal of the hold span: ceil(2^35 / 1401), exact for dividends below 2^24
    localparam int               RECIP_W     = 25;
    localparam int               RECIP_SHIFT = 35;
    localparam logic [RECIP_W-1:0] HOLD_RECIP = 25'd24525153;

    // Mode codes
    localparam logic [1:0] MODE_OFF     = 2'd0;
    localparam logic [1:0] MODE_BOUNCE  = 2'd1;
    localparam logic [1:0] MODE_INVERSE = 2'd2;
    localparam logic [1:0] MODE_SPARKLE = 2'd3;

    // Random seed and timing constants in ms
    localparam logic [31:0]          RAND_SEED       = 32'hA5A5_A5A5;
    localparam logic [DIVISOR_W-1:0] HOLD_BASE       = 11'd100;
    localparam logic [DIVISOR_W-1:0] HOLD_SPAN       = 11'd1401;
    localparam logic [DIVISOR_W-1:0] PERIOD_SHORT_MS = 11'd500;

    typedef struct packed {
        logic       action;
        logic [3:0] button_levels;
    } t_in_item;

    typedef struct packed {
        logic [7:0] led_pattern;
        logic       led_drive;
        logic [1:0] mode;
        logic       short_period;
    } t_out_item;

    // Remainder unit status and result
    typedef struct packed {
        logic                 done;
        logic [DIVISOR_W-1:0] remainder;
    } t_div_res;

endpackage

// File: hdl/dlps_div.sv
// Remainder by the hold span through one shared multiplier, three steps per request.
module dlps_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [dlps_pkg::DIV_W-1:0] i_dividend,
    output dlps_pkg::t_div_res         o_res
);
    import dlps_pkg::*;

    localparam int PROD_W = 2 * RECIP_W;
    localparam int QUO_W  = DIV_W + RECIP_W - RECIP_SHIFT;

    typedef enum logic [1:0] {S_IDLE, S_RECIP, S_BACK, S_SUB} t_state;

    t_state               r_state;
    logic                 r_done;
    logic [DIV_W-1:0]     r_x;
    logic [PROD_W-1:0]    r_prod;
    logic [DIVISOR_W-1:0] r_rem;

    logic [RECIP_W-1:0] mul_a;
    logic [RECIP_W-1:0] mul_b;
    logic [PROD_W-1:0]  mul_p;
    logic [DIV_W-1:0]   diff;

    // Shared multiplier: reciprocal estimate first, then quotient times span
    assign mul_a = (r_state == S_RECIP) ? RECIP_W'(r_x)
                                        : RECIP_W'(r_prod[RECIP_SHIFT +: QUO_W]);
    assign mul_b = (r_state == S_RECIP) ? HOLD_RECIP : RECIP_W'(HOLD_SPAN);
    assign mul_p = mul_a * mul_b;

    // Quotient times span never exceeds the dividend
    assign diff = r_x - r_prod[DIV_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_x     <= i_dividend;
                        r_state <= S_RECIP;
                    end
                end
                S_RECIP: begin
                    r_prod  <= mul_p;
                    r_state <= S_BACK;
                end
                S_BACK: begin
                    r_prod  <= mul_p;
                    r_state <= S_SUB;
                end
                S_SUB: begin
                    r_rem   <= diff[DIVISOR_W-1:0];
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_res.done      = r_done;
    assign o_res.remainder = r_rem;

endmodule

// File: hdl/debounced_led_pattern_sequencer.sv
// Top level: button debounce, LED mode sequencer and shared remainder unit.
// A request passes to S_DONE, which loads the output register; a sparkle frame that draws a
// new pattern first waits in S_MOD for the 3-step remainder unit and the frame-count step.
// Requests are taken only in idle, so one is finished before the next; a new request is
// taken while the last result waits, and a stalled output holds the next result back.
// Reset (synchronous, active low) restores debounce history, mode and random seed.
module debounced_led_pattern_sequencer #(
    parameter int LED_COUNT      = dlps_pkg::LED_COUNT_DEF,
    parameter int DEBOUNCE_DEPTH = dlps_pkg::DEBOUNCE_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  dlps_pkg::t_in_item  i_in,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output dlps_pkg::t_out_item o_out
);
    import dlps_pkg::*;

    localparam int POS_W = (LED_COUNT > 2) ? $clog2(LED_COUNT) : 1;
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(LED_COUNT - 1);
    localparam logic [POS_W-1:0] POS_TURN = POS_W'(LED_COUNT - 2);

    // Hold time thresholds for two and three short periods
    localparam logic [DIVISOR_W-1:0] SHORT_X2 = DIVISOR_W'(2 * PERIOD_SHORT_MS);
    localparam logic [DIVISOR_W-1:0] SHORT_X3 = DIVISOR_W'(3 * PERIOD_SHORT_MS);

    // Sparkle phase codes; the spare code acts as decay
    localparam logic [1:0] PH_DRAW  = 2'd0;
    localparam logic [1:0] PH_HOLD  = 2'd1;
    localparam logic [1:0] PH_DECAY = 2'd2;

    // Button roles
    localparam int BTN_PERIOD  = 0;
    localparam int BTN_BOUNCE  = 1;
    localparam int BTN_INVERSE = 2;
    localparam int BTN_SPARKLE = 3;

    typedef enum logic [1:0] {S_IDLE, S_MOD, S_DONE} t_state;

    t_state r_state, n_state;

    logic [DEBOUNCE_DEPTH-1:0] r_hist [BUTTON_COUNT];
    logic [DEBOUNCE_DEPTH-1:0] n_hist [BUTTON_COUNT];
    logic [BUTTON_COUNT-1:0]   r_stable, n_stable;
    logic [1:0]                r_mode, n_mode;
    logic [POS_W-1:0]          r_pos, n_pos;
    logic                      r_up, n_up;
    logic                      r_short, n_short;
    logic [31:0]               r_rand, n_rand;
    logic [LED_COUNT-1:0]      r_spat, n_spat;
    logic [1:0]                r_phase, n_phase;
    logic [7:0]                r_hold, n_hold;
    logic [7:0]                r_decay, n_decay;
    logic                      r_blank, n_blank;
    logic [LED_COUNT-1:0]      r_res_pat, n_res_pat;
    logic                      r_res_drive, n_res_drive;
    logic                      r_out_valid, n_out_valid;
    t_out_item                 r_out, n_out;

    logic             div_start;
    logic [DIV_W-1:0] div_a;
    t_div_res         div_res;

    logic in_acc;

    assign in_acc = i_in_valid && (r_state == S_IDLE);

    function automatic logic [31:0] xorshift(input logic [31:0] x);
        logic [31:0] y;
        y = x ^ (x << 13);
        y = y ^ (y >> 17);
        y = y ^ (y << 5);
        return y;
    endfunction

    dlps_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_a),
        .o_res      (div_res)
    );

    // Sequencer next state
    always_comb begin
        logic [DEBOUNCE_DEPTH-1:0] h;
        logic                      nxt;
        logic [BUTTON_COUNT-1:0]   fall;
        logic [POS_W-1:0]          pos;
        logic [LED_COUNT-1:0]      bpat;
        logic [LED_COUNT-1:0]      dpat;
        logic [31:0]               rnd;
        logic [DIVISOR_W-1:0]      ms;
        logic [7:0]                frames;

        n_state     = r_state;
        n_hist      = r_hist;
        n_stable    = r_stable;
        n_mode      = r_mode;
        n_pos       = r_pos;
        n_up        = r_up;
        n_short     = r_short;
        n_rand      = r_rand;
        n_spat      = r_spat;
        n_phase     = r_phase;
        n_hold      = r_hold;
        n_decay     = r_decay;
        n_blank     = r_blank;
        n_res_pat   = r_res_pat;
        n_res_drive = r_res_drive;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        div_start   = 1'b0;
        div_a       = '0;
        h           = '0;
        nxt         = 1'b0;
        fall        = '0;
        pos         = '0;
        bpat        = '0;
        dpat        = '0;
        rnd         = xorshift(r_rand);
        ms          = '0;
        frames      = '0;

        // Result taken downstream
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state     = S_DONE;
                    n_res_pat   = '0;
                    n_res_drive = 1'b1;
                    if (!i_in.action) begin
                        // Debounce each button; stable level moves only on full agreement
                        for (int b = 0; b < BUTTON_COUNT; b++) begin
                            h         = {r_hist[b][DEBOUNCE_DEPTH-2:0], i_in.button_levels[b]};
                            n_hist[b] = h;
                            nxt       = (h == '0) ? 1'b0 : ((h == '1) ? 1'b1 : r_stable[b]);
                            fall[b]   = r_stable[b] && !nxt;
                            n_stable[b] = nxt;
                        end
                        // Press commands in button order
                        if (fall[BTN_PERIOD]) begin
                            n_short = !r_short;
                        end
                        if (fall[BTN_BOUNCE]) begin
                            n_mode = MODE_BOUNCE;
                            n_pos  = '0;
                            n_up   = 1'b1;
                        end
                        if (fall[BTN_INVERSE]) begin
                            n_mode = MODE_INVERSE;
                            n_pos  = '0;
                            n_up   = 1'b1;
                        end
                        if (fall[BTN_SPARKLE]) begin
                            n_mode  = MODE_SPARKLE;
                            n_phase = PH_DRAW;
                            n_spat  = '0;
                            n_blank = 1'b1;
                        end
                        n_res_drive = fall[BTN_SPARKLE];
                    end else begin
                        case (r_mode)
                            MODE_OFF: begin
                                n_res_pat = '0;
                            end
                            MODE_BOUNCE, MODE_INVERSE: begin
                                pos  = (r_pos > POS_LAST) ? POS_LAST : r_pos;
                                bpat = LED_COUNT'(1) << pos;
                                if (r_up) begin
                                    if (pos >= POS_LAST) begin
                                        n_up  = 1'b0;
                                        n_pos = POS_TURN;
                                    end else begin
                                        n_pos = pos + 1'b1;
                                    end
                                end else begin
                                    if (pos == '0) begin
                                        n_up  = 1'b1;
                                        n_pos = POS_W'(1);
                                    end else begin
                                        n_pos = pos - 1'b1;
                                    end
                                end
                                n_res_pat = (r_mode == MODE_INVERSE) ? ~bpat : bpat;
                            end
                            default: begin
                                if (r_blank) begin
                                    // First sparkle frame stays dark
                                    n_blank   = 1'b0;
                                    n_res_pat = '0;
                                end else begin
                                    case (r_phase)
                                        PH_DRAW: begin
                                            n_rand    = rnd;
                                            n_spat    = rnd[LED_COUNT-1:0];
                                            n_decay   = '0;
                                            n_phase   = PH_HOLD;
                                            n_res_pat = rnd[LED_COUNT-1:0];
                                            div_start = 1'b1;
                                            div_a     = rnd[31:8];
                                            n_state   = S_MOD;
                                        end
                                        PH_HOLD: begin
                                            if (r_hold != '0) begin
                                                n_hold = r_hold - 1'b1;
                                            end else begin
                                                n_phase = PH_DECAY;
                                            end
                                            n_res_pat = r_spat;
                                        end
                                        default: begin
                                            dpat = r_spat;
                                            if (r_decay != '0) begin
                                                n_decay = r_decay - 1'b1;
                                            end else if (r_spat != '0) begin
                                                // Clear lowest lit LED and set a decay delay
                                                // of one frame before the next LED is cleared
                                                dpat    = r_spat & (r_spat - 1'b1);
                                                n_rand  = rnd;
                                                n_decay = 8'd1;
                                            end
                                            if (dpat == '0) begin
                                                n_phase = PH_DRAW;
                                            end
                                            n_spat    = dpat;
                                            n_res_pat = dpat;
                                        end
                                    endcase
                                end
                            end
                        endcase
                    end
                end
            end
            S_MOD: begin
                // Remainder ready: hold time in ms to frames at the current period
                if (div_res.done) begin
                    ms = HOLD_BASE + div_res.remainder;
                    if (r_short) begin
                        frames = (ms >= SHORT_X3) ? 8'd3 : ((ms >= SHORT_X2) ? 8'd2 : 8'd1);
                    end else begin
                        // 100 to 1500 ms always counts as one frame at the long period
                        frames = 8'd1;
                    end
                    n_hold  = frames;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // Load output register once it is free
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid        = 1'b1;
                    n_out.led_pattern  = 8'(32'(r_res_pat));
                    n_out.led_drive    = r_res_drive;
                    n_out.mode         = r_mode;
                    n_out.short_period = r_short;
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            for (int b = 0; b < BUTTON_COUNT; b++) begin
                r_hist[b] <= '1;
            end
            r_stable    <= '1;
            r_mode      <= MODE_OFF;
            r_pos       <= '0;
            r_up        <= 1'b1;
            r_short     <= 1'b0;
            r_rand      <= RAND_SEED;
            r_spat      <= '0;
            r_phase     <= PH_DRAW;
            r_hold      <= '0;
            r_decay     <= '0;
            r_blank     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_hist      <= n_hist;
            r_stable    <= n_stable;
            r_mode      <= n_mode;
            r_pos       <= n_pos;
            r_up        <= n_up;
            r_short     <= n_short;
            r_rand      <= n_rand;
            r_spat      <= n_spat;
            r_phase     <= n_phase;
            r_hold      <= n_hold;
            r_decay     <= n_decay;
            r_blank     <= n_blank;
            r_out_valid <= n_out_valid;
        end
        r_res_pat   <= n_res_pat;
        r_res_drive <= n_res_drive;
        r_out       <= n_out;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// File: hdl/dlps_checker.sv
// Port-level checks for the sequencer, bound to the top level.
module dlps_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input dlps_pkg::t_in_item  i_in,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input dlps_pkg::t_out_item o_out
);
    import dlps_pkg::*;

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result changed while stalled");

    // Undriven results are button samples and carry no pattern
    a_nodrive_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.led_drive |-> o_out.led_pattern == 8'd0)
        else $error("pattern present without drive");

    // Off mode shows nothing
    a_off_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.mode == MODE_OFF) |-> o_out.led_pattern == 8'd0)
        else $error("LEDs lit in off mode");

    // Bounce lights at most one LED
    a_bounce_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.mode == MODE_BOUNCE) |-> $onehot0(o_out.led_pattern))
        else $error("bounce lit more than one LED");

    // No result and input ready right after reset
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("output valid after reset");

endmodule

bind debounced_led_pattern_sequencer dlps_checker u_dlps_checker (.*);
